// ===== rtl/ghe_pkg.sv =====
package ghe_pkg;

   // field widths
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int HEAD_W = 16;
   localparam int MOVE_W = 16;

   // internal widths
   localparam int ANG_W  = 35;   // folded angle, degrees * 1e7
   localparam int XY_W   = 48;   // cordic x and y
   localparam int Z_W    = 36;   // cordic angle, Q30 radians
   localparam int TRIG_W = 34;   // stored sine and cosine, Q30
   localparam int MUL_W  = 34;   // multiplier operand
   localparam int PROD_W = 64;   // kept product
   localparam int H_W    = 61;   // clamped haversine term, Q60
   localparam int SQ_W   = 64;   // square root working registers
   localparam int CNT_W  = 6;
   localparam int SLOT_W = 3;

   localparam int unsigned CORDIC_ITER_DEF = 24;
   localparam int unsigned SQRT_STEPS      = 32;

   // constants
   localparam logic signed [XY_W-1:0]   CORDIC_KINV      = 48'sd652032874;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q30      = 36'sd1686629713;
   localparam logic signed [MUL_W-1:0]  RAD_SCALE        = 34'sd2012227630;
   localparam logic signed [MUL_W-1:0]  EARTH_DIAMETER_M = 34'sd12732000;
   localparam logic signed [ANG_W-1:0]  TURN_E7          = 35'sd3600000000;
   localparam logic signed [Z_W-1:0]    HEAD_ROUND       = 36'sd65536;
   localparam logic signed [Z_W-1:0]    HEAD_MAX         = 36'sd25736;
   localparam logic signed [Z_W-1:0]    HEAD_MIN         = -36'sd25736;
   localparam logic signed [PROD_W-1:0] ONE_Q60          = 64'sh1000_0000_0000_0000;
   localparam logic [MOVE_W-1:0]        MOVE_RESET       = 16'd10;

   // trig job slots
   localparam logic [SLOT_W-1:0] SLOT_REF       = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_FIX       = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_DLAT      = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_DLON_HALF = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_DLON      = 3'd4;

   typedef enum logic [5:0] {
      S_IDLE, S_FIRST, S_FOLD_LOAD, S_FOLD_WRAP, S_FOLD_QTR, S_ZMUL, S_ROT_INIT, S_ROT,
      S_ROT_STORE, S_HS1, S_HS2, S_HS3, S_HS4, S_HS5, S_CLAMP, S_SQ1, S_SQ_NEXT, S_SQ2,
      S_VEC_INIT, S_VEC, S_DIST_MUL, S_DIST_CMP, S_B1, S_B2, S_B3, S_B4, S_B5, S_HEAD,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_FIRST, OP_FOLD_LOAD, OP_FOLD_WRAP, OP_FOLD_QTR, OP_ROT_INIT, OP_ROT_STEP,
      OP_ROT_STORE, OP_HS_ACC0, OP_HS_SUM, OP_CLAMP, OP_SQ_STEP, OP_SQ_NEXT, OP_VEC_DIST,
      OP_VEC_BEAR, OP_VEC_STEP, OP_BY, OP_BX, OP_BX_SUB, OP_HEAD, OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      MUL_ANG_RAD, MUL_S1_S1, MUL_CA_CB, MUL_PROD_S2, MUL_PROD_CDL, MUL_HALF_DIST,
      MUL_SDL_CB, MUL_CA_SB, MUL_SA_CB
   } mul_sel_type;

   typedef struct packed {
      logic              load;
      dp_op_type         op;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  iter;
   } dp_cmd_type;

   typedef struct packed {
      logic ref_valid;
      logic ang_in_range;
      logic moved;
   } dp_stat_type;

   // elementary cordic angle, Q30
   function automatic logic signed [Z_W-1:0] atan_step(input logic [CNT_W-1:0] i);
      logic signed [Z_W-1:0] r;
      unique case (i)
         6'd0: r = 36'sd843314857;
         6'd1: r = 36'sd497837829;
         6'd2: r = 36'sd263043837;
         6'd3: r = 36'sd133525159;
         6'd4: r = 36'sd67021687;
         6'd5: r = 36'sd33543516;
         6'd6: r = 36'sd16775851;
         6'd7: r = 36'sd8388437;
         6'd8: r = 36'sd4194283;
         6'd9: r = 36'sd2097149;
         default: r = (i <= 6'd30) ? (Z_W'(1) << (6'd30 - i)) : '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ghe_if.sv =====
interface ghe_req_if import ghe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] latitude;
   logic signed [LON_W-1:0] longitude;
   modport source (output valid, latitude, longitude, input ready);
   modport sink (input valid, latitude, longitude, output ready);
endinterface

interface ghe_rsp_if import ghe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [HEAD_W-1:0] heading;
   logic                     heading_updated;
   modport source (output valid, heading, heading_updated, input ready);
   modport sink (input valid, heading, heading_updated, output ready);
endinterface

interface ghe_csr_if import ghe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MOVE_W-1:0] min_move_meters;
   modport source (output valid, min_move_meters, input ready);
   modport sink (input valid, min_move_meters, output ready);
endinterface

// ===== rtl/gps_heading_estimator_top.sv =====
// each fix after the first is worked through the shared cordic and the bit-serial square
// root; the bearing is only worked out when the fix reaches the threshold and updates
// the heading. one fix at a time; a result word may wait while the next fix is taken.
// synchronous reset clears the reference and heading and sets the threshold to 10 m.
module gps_heading_estimator_top import ghe_pkg::*; #(
   parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ghe_req_if.sink  req_ch,
   ghe_rsp_if.source rsp_ch,
   ghe_csr_if.sink  csr_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // threshold register takes a word at any time
   assign csr_ch.ready = 1'b1;

   // sequencer
   ghe_ctrl #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // arithmetic
   ghe_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_latitude        (req_ch.latitude),
      .req_longitude       (req_ch.longitude),
      .csr_we              (csr_ch.valid),
      .csr_data            (csr_ch.min_move_meters),
      .rsp_heading         (rsp_ch.heading),
      .rsp_heading_updated (rsp_ch.heading_updated)
   );

endmodule

// ===== rtl/ghe_ctrl.sv =====
module ghe_ctrl import ghe_pkg::*; #(
   parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_ITERATIONS - 1);
   localparam logic [CNT_W-1:0] LAST_SQ   = CNT_W'(SQRT_STEPS - 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      slot_in  = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            slot_in = SLOT_REF;
            if (req_valid) begin
               state_in = stat.ref_valid ? S_FOLD_LOAD : S_FIRST;
            end
         end
         S_FIRST:     state_in = S_DONE;
         S_FOLD_LOAD: state_in = S_FOLD_WRAP;
         S_FOLD_WRAP: begin
            if (stat.ang_in_range) begin
               state_in = S_FOLD_QTR;
            end
         end
         S_FOLD_QTR:  state_in = S_ZMUL;
         S_ZMUL:      state_in = S_ROT_INIT;
         S_ROT_INIT:  state_in = S_ROT;
         S_ROT: begin
            if (cnt_ff == LAST_ITER) begin
               state_in = S_ROT_STORE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ROT_STORE: begin
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_DLON_HALF) begin
               state_in = S_HS1;
            end else if (slot_ff == SLOT_DLON) begin
               state_in = S_B1;
            end else begin
               state_in = S_FOLD_LOAD;
            end
         end
         S_HS1:   state_in = S_HS2;
         S_HS2:   state_in = S_HS3;
         S_HS3:   state_in = S_HS4;
         S_HS4:   state_in = S_HS5;
         S_HS5:   state_in = S_CLAMP;
         S_CLAMP: state_in = S_SQ1;
         S_SQ1: begin
            if (cnt_ff == LAST_SQ) begin
               state_in = S_SQ_NEXT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SQ_NEXT: state_in = S_SQ2;
         S_SQ2: begin
            if (cnt_ff == LAST_SQ) begin
               state_in = S_VEC_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_VEC_INIT: state_in = S_VEC;
         S_VEC: begin
            if (cnt_ff == LAST_ITER) begin
               state_in = (slot_ff == SLOT_DLON) ? S_DIST_MUL : S_HEAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIST_MUL: state_in = S_DIST_CMP;
         S_DIST_CMP: state_in = stat.moved ? S_FOLD_LOAD : S_DONE;
         S_B1:       state_in = S_B2;
         S_B2:       state_in = S_B3;
         S_B3:       state_in = S_B4;
         S_B4:       state_in = S_B5;
         S_B5:       state_in = S_VEC_INIT;
         S_HEAD:     state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.op      = OP_NONE;
      cmd.mul_en  = 1'b0;
      cmd.mul_sel = MUL_ANG_RAD;
      cmd.slot    = slot_ff;
      cmd.iter    = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_FIRST:     cmd.op = OP_FIRST;
         S_FOLD_LOAD: cmd.op = OP_FOLD_LOAD;
         S_FOLD_WRAP: cmd.op = OP_FOLD_WRAP;
         S_FOLD_QTR:  cmd.op = OP_FOLD_QTR;
         S_ZMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ANG_RAD;
         end
         S_ROT_INIT:  cmd.op = OP_ROT_INIT;
         S_ROT:       cmd.op = OP_ROT_STEP;
         S_ROT_STORE: cmd.op = OP_ROT_STORE;
         S_HS1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_S1_S1;
         end
         S_HS2: begin
            cmd.op      = OP_HS_ACC0;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CA_CB;
         end
         S_HS3, S_HS4: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROD_S2;
         end
         S_HS5:      cmd.op = OP_HS_SUM;
         S_CLAMP:    cmd.op = OP_CLAMP;
         S_SQ1:      cmd.op = OP_SQ_STEP;
         S_SQ_NEXT:  cmd.op = OP_SQ_NEXT;
         S_SQ2:      cmd.op = OP_SQ_STEP;
         S_VEC_INIT: cmd.op = (slot_ff == SLOT_DLON) ? OP_VEC_DIST : OP_VEC_BEAR;
         S_VEC:      cmd.op = OP_VEC_STEP;
         S_DIST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HALF_DIST;
         end
         S_DIST_CMP: cmd.op = OP_NONE;
         S_B1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SDL_CB;
         end
         S_B2: begin
            cmd.op      = OP_BY;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CA_SB;
         end
         S_B3: begin
            cmd.op      = OP_BX;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SA_CB;
         end
         S_B4: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROD_CDL;
         end
         S_B5:       cmd.op = OP_BX_SUB;
         S_HEAD:     cmd.op = OP_HEAD;
         S_DONE:     cmd.op = out_free ? OP_EMIT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // result word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         slot_ff      <= SLOT_REF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ghe_dp.sv =====
module ghe_dp import ghe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   input  logic signed [LAT_W-1:0]  req_latitude,
   input  logic signed [LON_W-1:0]  req_longitude,
   input  logic                     csr_we,
   input  logic [MOVE_W-1:0]        csr_data,
   output logic signed [HEAD_W-1:0] rsp_heading,
   output logic                     rsp_heading_updated
);

   // fix, reference and configuration
   logic signed [LAT_W-1:0]  lat_ff, lat_in, ref_lat_ff, ref_lat_in;
   logic signed [LON_W-1:0]  lon_ff, lon_in, ref_lon_ff, ref_lon_in;
   logic                     ref_valid_ff, ref_valid_in;
   logic signed [HEAD_W-1:0] head_ff, head_in, out_head_ff, out_head_in;
   logic                     upd_ff, upd_in, out_upd_ff, out_upd_in;
   logic [MOVE_W-1:0]        move_ff, move_in;

   // angle fold
   logic signed [ANG_W-1:0]  ang_ff, ang_in;
   logic                     half_ff, half_in, neg_ff, neg_in;
   logic signed [ANG_W-1:0]  period, p_half, p_qtr, fold_src;
   logic                     src_half;

   // cordic
   logic signed [XY_W-1:0]   cx_ff, cx_in, cy_ff, cy_in, dx, dy, vx, vy;
   logic signed [Z_W-1:0]    cz_ff, cz_in, at;
   logic                     dir_sub;

   // stored sines and cosines
   logic signed [TRIG_W-1:0] sa_ff, ca_ff, sb_ff, cb_ff, s1_ff, s2_ff, sdl_ff, cdl_ff;
   logic signed [TRIG_W-1:0] sa_in, ca_in, sb_in, cb_in, s1_in, s2_in, sdl_in, cdl_in;
   logic signed [XY_W-1:0]   rs, rc;

   // multiplier
   logic signed [MUL_W-1:0]   ma, mb, prod_q30;
   logic signed [2*MUL_W-1:0] mul_full;
   logic signed [PROD_W-1:0]  prod_ff, prod_in, acc_ff, acc_in, thr;
   logic signed [XY_W-1:0]    prod_q20;

   // square root and bearing vector
   logic [H_W-1:0]           h_ff, h_in;
   logic [SQ_W-1:0]          sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_bit, sq_t;
   logic [5:0]               sq_sh;
   logic signed [XY_W-1:0]   sqa_ff, sqa_in, by_ff, by_in, bx_ff, bx_in;
   logic signed [Z_W-1:0]    hd;

   // fold constants for full or half angle
   always_comb begin
      period = half_ff ? (TURN_E7 <<< 1) : TURN_E7;
      p_half = period >>> 1;
      p_qtr  = period >>> 2;
   end

   // fold source per slot
   always_comb begin
      unique case (cmd.slot)
         SLOT_REF: begin
            fold_src = ANG_W'(ref_lat_ff);
            src_half = 1'b0;
         end
         SLOT_FIX: begin
            fold_src = ANG_W'(lat_ff);
            src_half = 1'b0;
         end
         SLOT_DLAT: begin
            fold_src = ANG_W'(lat_ff) - ANG_W'(ref_lat_ff);
            src_half = 1'b1;
         end
         SLOT_DLON_HALF: begin
            fold_src = ANG_W'(lon_ff) - ANG_W'(ref_lon_ff);
            src_half = 1'b1;
         end
         default: begin
            fold_src = ANG_W'(lon_ff) - ANG_W'(ref_lon_ff);
            src_half = 1'b0;
         end
      endcase
   end

   // multiplier operands
   assign prod_q30 = MUL_W'(prod_ff >>> 30);
   assign prod_q20 = XY_W'(prod_ff >>> 20);
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ANG_RAD: begin
            ma = ang_ff[MUL_W-1:0];
            mb = RAD_SCALE;
         end
         MUL_S1_S1: begin
            ma = s1_ff;
            mb = s1_ff;
         end
         MUL_CA_CB: begin
            ma = ca_ff;
            mb = cb_ff;
         end
         MUL_PROD_S2: begin
            ma = prod_q30;
            mb = s2_ff;
         end
         MUL_PROD_CDL: begin
            ma = prod_q30;
            mb = cdl_ff;
         end
         MUL_HALF_DIST: begin
            ma = cz_ff[MUL_W-1:0];
            mb = EARTH_DIAMETER_M;
         end
         MUL_SDL_CB: begin
            ma = sdl_ff;
            mb = cb_ff;
         end
         MUL_CA_SB: begin
            ma = ca_ff;
            mb = sb_ff;
         end
         MUL_SA_CB: begin
            ma = sa_ff;
            mb = cb_ff;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end
   assign mul_full = ma * mb;

   // cordic step terms, shared by rotation and vectoring
   assign dx      = cy_ff >>> cmd.iter;
   assign dy      = cx_ff >>> cmd.iter;
   assign at      = atan_step(cmd.iter);
   assign dir_sub = (cmd.op == OP_VEC_STEP) ? cy_ff[XY_W-1] : !cz_ff[Z_W-1];
   assign rs      = neg_ff ? -cy_ff : cy_ff;
   assign rc      = neg_ff ? -cx_ff : cx_ff;

   // vectoring input
   always_comb begin
      if (cmd.op == OP_VEC_DIST) begin
         vx = XY_W'(sq_r_ff);
         vy = sqa_ff;
      end else begin
         vx = bx_ff;
         vy = by_ff;
      end
   end

   // square root step
   assign sq_sh  = 6'd62 - {cmd.iter[4:0], 1'b0};
   assign sq_bit = SQ_W'(1) << sq_sh;
   assign sq_t   = sq_r_ff + sq_bit;

   // distance threshold and heading rounding
   assign thr = PROD_W'({move_ff, 30'b0});
   assign hd  = (cz_ff + HEAD_ROUND) >>> 17;

   // status
   assign stat.ref_valid    = ref_valid_ff;
   assign stat.ang_in_range = !(ang_ff > p_half) && !(ang_ff < -p_half);
   assign stat.moved        = prod_ff >= thr;

   assign rsp_heading         = out_head_ff;
   assign rsp_heading_updated = out_upd_ff;

   // next values
   always_comb begin
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      ref_lat_in   = ref_lat_ff;
      ref_lon_in   = ref_lon_ff;
      ref_valid_in = ref_valid_ff;
      head_in      = head_ff;
      upd_in       = upd_ff;
      out_head_in  = out_head_ff;
      out_upd_in   = out_upd_ff;
      move_in      = csr_we ? csr_data : move_ff;
      ang_in       = ang_ff;
      half_in      = half_ff;
      neg_in       = neg_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      sa_in        = sa_ff;
      ca_in        = ca_ff;
      sb_in        = sb_ff;
      cb_in        = cb_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      sdl_in       = sdl_ff;
      cdl_in       = cdl_ff;
      prod_in      = cmd.mul_en ? mul_full[PROD_W-1:0] : prod_ff;
      acc_in       = acc_ff;
      h_in         = h_ff;
      sq_n_in      = sq_n_ff;
      sq_r_in      = sq_r_ff;
      sqa_in       = sqa_ff;
      by_in        = by_ff;
      bx_in        = bx_ff;

      if (cmd.load) begin
         lat_in = req_latitude;
         lon_in = req_longitude;
         upd_in = 1'b0;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_FIRST: begin
            ref_lat_in   = lat_ff;
            ref_lon_in   = lon_ff;
            ref_valid_in = 1'b1;
         end
         OP_FOLD_LOAD: begin
            ang_in  = fold_src;
            half_in = src_half;
         end
         // whole turns off
         OP_FOLD_WRAP: begin
            if (ang_ff > p_half) begin
               ang_in = ang_ff - period;
            end else if (ang_ff < -p_half) begin
               ang_in = ang_ff + period;
            end
         end
         // into [-90, 90] degrees, sign flip remembered
         OP_FOLD_QTR: begin
            neg_in = 1'b0;
            if (ang_ff > p_qtr) begin
               ang_in = ang_ff - p_half;
               neg_in = 1'b1;
            end else if (ang_ff < -p_qtr) begin
               ang_in = ang_ff + p_half;
               neg_in = 1'b1;
            end
         end
         OP_ROT_INIT: begin
            cx_in = CORDIC_KINV;
            cy_in = '0;
            cz_in = half_ff ? Z_W'(prod_ff >>> 31) : Z_W'(prod_ff >>> 30);
         end
         OP_ROT_STEP, OP_VEC_STEP: begin
            if (dir_sub) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + at;
            end
         end
         OP_ROT_STORE: begin
            unique case (cmd.slot)
               SLOT_REF: begin
                  sa_in = TRIG_W'(rs);
                  ca_in = TRIG_W'(rc);
               end
               SLOT_FIX: begin
                  sb_in = TRIG_W'(rs);
                  cb_in = TRIG_W'(rc);
               end
               SLOT_DLAT:      s1_in = TRIG_W'(rs);
               SLOT_DLON_HALF: s2_in = TRIG_W'(rs);
               default: begin
                  sdl_in = TRIG_W'(rs);
                  cdl_in = TRIG_W'(rc);
               end
            endcase
         end
         OP_HS_ACC0: acc_in = prod_ff;
         OP_HS_SUM:  acc_in = acc_ff + prod_ff;
         // clamp to [0, 1] and start the first root
         OP_CLAMP: begin
            if (acc_ff[PROD_W-1]) begin
               h_in = '0;
            end else if (acc_ff > ONE_Q60) begin
               h_in = H_W'(ONE_Q60);
            end else begin
               h_in = H_W'(acc_ff);
            end
            sq_n_in = SQ_W'(h_in);
            sq_r_in = '0;
         end
         OP_SQ_STEP: begin
            if (sq_n_ff >= sq_t) begin
               sq_n_in = sq_n_ff - sq_t;
               sq_r_in = (sq_r_ff >> 1) + sq_bit;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
         end
         OP_SQ_NEXT: begin
            sqa_in  = XY_W'(sq_r_ff);
            sq_n_in = SQ_W'(ONE_Q60) - SQ_W'(h_ff);
            sq_r_in = '0;
         end
         // left half plane turned by a quarter
         OP_VEC_DIST, OP_VEC_BEAR: begin
            if (vx[XY_W-1]) begin
               if (!vy[XY_W-1]) begin
                  cx_in = vy;
                  cy_in = -vx;
                  cz_in = HALF_PI_Q30;
               end else begin
                  cx_in = -vy;
                  cy_in = vx;
                  cz_in = -HALF_PI_Q30;
               end
            end else begin
               cx_in = vx;
               cy_in = vy;
               cz_in = '0;
            end
         end
         OP_BY:     by_in = prod_q20;
         OP_BX:     bx_in = prod_q20;
         OP_BX_SUB: bx_in = bx_ff - prod_q20;
         OP_HEAD: begin
            if (hd > HEAD_MAX) begin
               head_in = HEAD_W'(HEAD_MAX);
            end else if (hd < HEAD_MIN) begin
               head_in = HEAD_W'(HEAD_MIN);
            end else begin
               head_in = HEAD_W'(hd);
            end
            ref_lat_in = lat_ff;
            ref_lon_in = lon_ff;
            upd_in     = 1'b1;
         end
         OP_EMIT: begin
            out_head_in = head_ff;
            out_upd_in  = upd_ff;
         end
         default: begin
         end
      endcase
   end

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff   <= '0;
         ref_lon_ff   <= '0;
         ref_valid_ff <= 1'b0;
         head_ff      <= '0;
         move_ff      <= MOVE_RESET;
      end else begin
         ref_lat_ff   <= ref_lat_in;
         ref_lon_ff   <= ref_lon_in;
         ref_valid_ff <= ref_valid_in;
         head_ff      <= head_in;
         move_ff      <= move_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lat_ff      <= lat_in;
      lon_ff      <= lon_in;
      upd_ff      <= upd_in;
      out_head_ff <= out_head_in;
      out_upd_ff  <= out_upd_in;
      ang_ff      <= ang_in;
      half_ff     <= half_in;
      neg_ff      <= neg_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      sa_ff       <= sa_in;
      ca_ff       <= ca_in;
      sb_ff       <= sb_in;
      cb_ff       <= cb_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      sdl_ff      <= sdl_in;
      cdl_ff      <= cdl_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      h_ff        <= h_in;
      sq_n_ff     <= sq_n_in;
      sq_r_ff     <= sq_r_in;
      sqa_ff      <= sqa_in;
      by_ff       <= by_in;
      bx_ff       <= bx_in;
   end

endmodule
